>>> hdl/rvex_pkg.sv
// Shared opcodes, function codes and decode types for the RV32I execute stage.
`default_nettype none
package rvex_pkg;

  // Base opcodes
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_FENCE  = 7'h0F;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  // funct7 that selects SUB and SRA
  localparam logic [6:0] F7_ALT = 7'h20;

  // ALU funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Branch funct3 codes
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BEQ2 = 3'd2;
  localparam logic [2:0] F3_BNE2 = 3'd3;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Load and store size codes
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  // Store lane patterns before the offset shift
  localparam logic [3:0] MASK_BYTE = 4'b0001;
  localparam logic [3:0] MASK_HALF = 4'b0011;
  localparam logic [3:0] MASK_WORD = 4'b1111;

  // Decoded control for one instruction
  typedef struct packed {
    logic       is_opimm;
    logic       is_op;
    logic       is_lui;
    logic       is_auipc;
    logic       is_jal;
    logic       is_jalr;
    logic       is_branch;
    logic       is_load;
    logic       is_store;
    logic       bad;
    logic       wb;
    logic       alt;
    logic [2:0] f3;
    logic [4:0] rd;
  } ctrl_t;

endpackage
`default_nettype wire

>>> hdl/rvex_decode.sv
// Instruction decoder: opcode class, fields and format immediate.
`default_nettype none
module rvex_decode (
  input  wire logic [31:0]    instruction,
  output rvex_pkg::ctrl_t     ctrl,
  output logic        [31:0]  imm
);

  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] imm_j;

  // Build the immediate of every format, sign-extended but for the U format
  assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
  assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
  assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
                  instruction[30:25], instruction[11:8], 1'b0};
  assign imm_u = {instruction[31:12], 12'b0};
  assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                  instruction[20], instruction[30:21], 1'b0};

  // Classify the opcode and pick the immediate
  always_comb begin
    ctrl     = '0;
    ctrl.f3  = instruction[14:12];
    ctrl.rd  = instruction[11:7];
    ctrl.alt = (instruction[31:25] == rvex_pkg::F7_ALT);
    imm      = imm_i;
    unique case (instruction[6:0]) inside
      rvex_pkg::OPC_OPIMM: begin
        ctrl.is_opimm = 1'b1;
      end
      rvex_pkg::OPC_OP: begin
        ctrl.is_op = 1'b1;
      end
      rvex_pkg::OPC_LUI: begin
        ctrl.is_lui = 1'b1;
        imm         = imm_u;
      end
      rvex_pkg::OPC_AUIPC: begin
        ctrl.is_auipc = 1'b1;
        imm           = imm_u;
      end
      rvex_pkg::OPC_JAL: begin
        ctrl.is_jal = 1'b1;
        imm         = imm_j;
      end
      rvex_pkg::OPC_JALR: begin
        ctrl.is_jalr = 1'b1;
      end
      rvex_pkg::OPC_BRANCH: begin
        ctrl.is_branch = 1'b1;
        imm            = imm_b;
      end
      rvex_pkg::OPC_LOAD: begin
        ctrl.is_load = 1'b1;
      end
      rvex_pkg::OPC_STORE: begin
        ctrl.is_store = 1'b1;
        imm           = imm_s;
      end
      rvex_pkg::OPC_FENCE, rvex_pkg::OPC_SYSTEM: begin
      end
      default: begin
        ctrl.bad = 1'b1;
      end
    endcase
    ctrl.wb = ctrl.is_opimm | ctrl.is_op | ctrl.is_lui | ctrl.is_auipc |
              ctrl.is_jal | ctrl.is_jalr | ctrl.is_load;
  end

endmodule
`default_nettype wire

>>> hdl/rvex_alu.sv
// Integer ALU with shifter and branch comparator.
`default_nettype none
module rvex_alu (
  input  wire logic [2:0]  f3,
  input  wire logic        sub,
  input  wire logic        arith,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [31:0] c,
  output logic      [31:0] y,
  output logic             taken
);

  logic [4:0] sh;
  logic       lt_ab;
  logic       ltu_ab;
  logic       eq_ac;
  logic       lt_ac;
  logic       ltu_ac;

  assign sh     = b[4:0];
  assign lt_ab  = ($signed(a) < $signed(b));
  assign ltu_ab = (a < b);
  assign eq_ac  = (a == c);
  assign lt_ac  = ($signed(a) < $signed(c));
  assign ltu_ac = (a < c);

  // Select the ALU operation
  always_comb begin
    case (f3)
      rvex_pkg::F3_ADD:  y = sub ? (a - b) : (a + b);
      rvex_pkg::F3_SLL:  y = a << sh;
      rvex_pkg::F3_SLT:  y = {31'b0, lt_ab};
      rvex_pkg::F3_SLTU: y = {31'b0, ltu_ab};
      rvex_pkg::F3_XOR:  y = a ^ b;
      rvex_pkg::F3_SRL:  y = arith ? $unsigned($signed(a) >>> sh) : (a >> sh);
      rvex_pkg::F3_OR:   y = a | b;
      default:           y = a & b;
    endcase
  end

  // Resolve the branch condition on rs1 against rs2
  always_comb begin
    case (f3) inside
      rvex_pkg::F3_BEQ, rvex_pkg::F3_BEQ2: taken = eq_ac;
      rvex_pkg::F3_BNE, rvex_pkg::F3_BNE2: taken = !eq_ac;
      rvex_pkg::F3_BLT:                    taken = lt_ac;
      rvex_pkg::F3_BGE:                    taken = !lt_ac;
      rvex_pkg::F3_BLTU:                   taken = ltu_ac;
      default:                             taken = !ltu_ac;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/rv32i_execute_stage_top.sv
// Top level of the three-stage RV32I execute pipeline.
//
//   channel   | handshake          | payload
//   ----------+--------------------+---------------------------------------------
//   command   | start / busy       | instruction, pc, rs1_value, rs2_value,
//             |                    | load_word
//   result    | done (one cycle)   | write_enable, dest_reg, write_value, new_pc,
//             |                    | mem_address, mem_read, mem_write,
//             |                    | store_data, byte_mask, illegal
//
// One beat enters every clock; its result passes the stage 1, 2 and 3 registers to done.
// Stage 1 decodes and picks the immediate, stage 2 runs the ALU, the address
// and target adders and the branch compare, stage 3 aligns loads and stores.
// busy stays low: the pipeline never stalls; the receiver must take every beat, which the block does not enforce.
// Synchronous reset clears the stage valid bits; payload is not reset.
`default_nettype none
module rv32i_execute_stage_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] instruction,
  input  wire logic [31:0] pc,
  input  wire logic [31:0] rs1_value,
  input  wire logic [31:0] rs2_value,
  input  wire logic [31:0] load_word,
  output logic             done,
  output logic             write_enable,
  output logic [4:0]       dest_reg,
  output logic [31:0]      write_value,
  output logic [31:0]      new_pc,
  output logic [31:0]      mem_address,
  output logic             mem_read,
  output logic             mem_write,
  output logic [31:0]      store_data,
  output logic [3:0]       byte_mask,
  output logic             illegal
);

  rvex_pkg::ctrl_t dec_ctrl;
  logic [31:0]     dec_imm;

  // Stage 1 registers
  logic            s1_valid;
  rvex_pkg::ctrl_t s1_ctrl;
  logic [31:0]     s1_imm;
  logic [31:0]     s1_pc;
  logic [31:0]     s1_r1;
  logic [31:0]     s1_r2;
  logic [31:0]     s1_lw;

  // Stage 2 registers
  logic            s2_valid;
  rvex_pkg::ctrl_t s2_ctrl;
  logic [31:0]     s2_val;
  logic [31:0]     s2_npc;
  logic [31:0]     s2_addr;
  logic [31:0]     s2_r2;
  logic [31:0]     s2_lw;

  logic [31:0]     alu_b;
  logic [31:0]     alu_y;
  logic            br_taken;
  logic [31:0]     sum_addr;
  logic [31:0]     sum_pc;
  logic [31:0]     seq_pc;
  logic [31:0]     val_next;
  logic [31:0]     npc_next;

  logic [1:0]      off;
  logic [31:0]     ld_shift;
  logic [31:0]     ld_val;
  logic [3:0]      mask_base;
  logic [31:0]     wval_next;

  assign busy = 1'b0;

  rvex_decode u_decode (
    .instruction (instruction),
    .ctrl        (dec_ctrl),
    .imm         (dec_imm)
  );

  // Stage 1: capture the beat with its decode
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_ctrl <= dec_ctrl;
    s1_imm  <= dec_imm;
    s1_pc   <= pc;
    s1_r1   <= rs1_value;
    s1_r2   <= rs2_value;
    s1_lw   <= load_word;
  end

  assign alu_b = s1_ctrl.is_op ? s1_r2 : s1_imm;

  rvex_alu u_alu (
    .f3    (s1_ctrl.f3),
    .sub   (s1_ctrl.is_op && s1_ctrl.alt),
    .arith (s1_ctrl.alt),
    .a     (s1_r1),
    .b     (alu_b),
    .c     (s1_r2),
    .y     (alu_y),
    .taken (br_taken)
  );

  assign sum_addr = s1_r1 + s1_imm;
  assign sum_pc   = s1_pc + s1_imm;
  assign seq_pc   = s1_pc + 32'd4;

  // Pick the write-back value and the next pc
  always_comb begin
    val_next = alu_y;
    if (s1_ctrl.is_lui) begin
      val_next = s1_imm;
    end else if (s1_ctrl.is_auipc) begin
      val_next = sum_pc;
    end else if (s1_ctrl.is_jal || s1_ctrl.is_jalr) begin
      val_next = seq_pc;
    end
    npc_next = seq_pc;
    if (s1_ctrl.is_jal || (s1_ctrl.is_branch && br_taken)) begin
      npc_next = sum_pc;
    end else if (s1_ctrl.is_jalr) begin
      npc_next = {sum_addr[31:1], 1'b0};
    end
  end

  // Stage 2: hold ALU and adder results
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_ctrl <= s1_ctrl;
    s2_val  <= val_next;
    s2_npc  <= npc_next;
    s2_addr <= sum_addr;
    s2_r2   <= s1_r2;
    s2_lw   <= s1_lw;
  end

  assign off      = s2_addr[1:0];
  assign ld_shift = s2_lw >> {off, 3'b000};

  // Extend the aligned load value
  always_comb begin
    case (s2_ctrl.f3)
      rvex_pkg::F3_LB:  ld_val = {{24{ld_shift[7]}}, ld_shift[7:0]};
      rvex_pkg::F3_LH:  ld_val = {{16{ld_shift[15]}}, ld_shift[15:0]};
      rvex_pkg::F3_LBU: ld_val = {24'b0, ld_shift[7:0]};
      rvex_pkg::F3_LHU: ld_val = {16'b0, ld_shift[15:0]};
      default:          ld_val = ld_shift;
    endcase
  end

  // Lane pattern for the store size
  always_comb begin
    case (s2_ctrl.f3)
      rvex_pkg::F3_LB: mask_base = rvex_pkg::MASK_BYTE;
      rvex_pkg::F3_LH: mask_base = rvex_pkg::MASK_HALF;
      rvex_pkg::F3_LW: mask_base = rvex_pkg::MASK_WORD;
      default:         mask_base = 4'b0000;
    endcase
  end

  assign wval_next = s2_ctrl.is_load ? ld_val : s2_val;

  // Stage 3: drive the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
    write_enable <= s2_ctrl.wb && (s2_ctrl.rd != 5'd0);
    dest_reg     <= s2_ctrl.wb ? s2_ctrl.rd : 5'd0;
    write_value  <= s2_ctrl.wb ? wval_next : 32'd0;
    new_pc       <= s2_npc;
    mem_address  <= (s2_ctrl.is_load || s2_ctrl.is_store) ? s2_addr : 32'd0;
    mem_read     <= s2_ctrl.is_load;
    mem_write    <= s2_ctrl.is_store;
    store_data   <= s2_ctrl.is_store ? (s2_r2 << {off, 3'b000}) : 32'd0;
    byte_mask    <= s2_ctrl.is_store ? (mask_base << off) : 4'b0000;
    illegal      <= s2_ctrl.bad;
  end

endmodule
`default_nettype wire

>>> hdl/rvex_checker.sv
// Port-level checks for the execute pipeline, bound to the top level.
`default_nettype none
module rvex_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic        write_enable,
  input wire logic        mem_read,
  input wire logic        mem_write,
  input wire logic [31:0] mem_address,
  input wire logic [3:0]  byte_mask,
  input wire logic        illegal
);

  // Every accepted beat comes out on done
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted beat did not complete after three cycles");

  // No result without an earlier accepted beat
  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result beat without a matching command");

  // Stores never write back
  a_store_no_wb : assert property (@(posedge clk) disable iff (rst)
    (done && mem_write) |-> !write_enable)
    else $error("store wrote the register file");

  // Illegal opcodes have no side effects
  a_illegal_quiet : assert property (@(posedge clk) disable iff (rst)
    (done && illegal) |-> (!write_enable && !mem_read && !mem_write))
    else $error("illegal instruction caused a side effect");

  // A full-word mask only at an aligned address
  a_word_aligned : assert property (@(posedge clk) disable iff (rst)
    (done && mem_write && (byte_mask == 4'b1111)) |-> (mem_address[1:0] == 2'b00))
    else $error("word lanes at a misaligned address");

endmodule

bind rv32i_execute_stage_top rvex_checker u_rvex_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .write_enable (write_enable),
  .mem_read     (mem_read),
  .mem_write    (mem_write),
  .mem_address  (mem_address),
  .byte_mask    (byte_mask),
  .illegal      (illegal)
);
`default_nettype wire
